/* rtl/bisync_tx_framer_parity_unit_defines.svh */
`ifndef BISYNC_TX_FRAMER_PARITY_UNIT_DEFINES_SVH
`define BISYNC_TX_FRAMER_PARITY_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BSF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsf check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define BSF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsf check failed");

`endif

/* rtl/bsf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bsf_pkg;

  localparam int SYN_COUNT_DEF    = 2;
  localparam int HEADER_BYTES_DEF = 3;
  localparam int RESULT_CAP       = 8;

  localparam logic [7:0] CH_DLE    = 8'h10;
  localparam logic [7:0] CH_STX    = 8'h02;
  localparam logic [7:0] CH_ETB    = 8'h17;
  localparam logic [7:0] CH_ETX    = 8'h03;
  localparam logic [7:0] CH_ITB    = 8'h1F;
  localparam logic [7:0] CH_PAD    = 8'hFF;
  localparam logic [7:0] PAD_FIXED = 8'h7F;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_CHAR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARITY_FIX = 2'd1;

  // scanner modes
  localparam logic [1:0] SCAN_NORMAL = 2'd0;
  localparam logic [1:0] SCAN_DLE    = 2'd1;
  localparam logic [1:0] SCAN_BCC1   = 2'd2;
  localparam logic [1:0] SCAN_BCC2   = 2'd3;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_first;
    logic       frame_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       line_last;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/bisync_tx_framer_parity_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Bisync transmit framer. Each accepted frame byte yields zero or more line bytes
// (SYNs on a first byte, the byte itself once the header is dropped, a pad on a
// last byte), all passed through one odd-parity scanner. While the output is free,
// one line byte moves into the single output register per clock: an item with n
// line bytes (n up to SYN_COUNT + 2, bytes past the result cap still stepping the
// scanner) lets the next item in with its last, so items with no or one line byte
// are taken every cycle. While a result waits on out_stall the input keeps taking
// items until one with a line byte is in, then stalls until the output moves again.
module bisync_tx_framer_parity_unit #(
  parameter int SYN_COUNT    = bsf_pkg::SYN_COUNT_DEF,
  parameter int HEADER_BYTES = bsf_pkg::HEADER_BYTES_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire [bsf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [bsf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire bsf_pkg::in_item_t           in_data,
  output logic                             out_valid,
  input  wire                              out_stall,
  output bsf_pkg::out_item_t               out_data
);

  import bsf_pkg::*;

  localparam int SYN_W = $clog2(SYN_COUNT + 1);
  localparam int HDR_W = (HEADER_BYTES > 0) ? $clog2(HEADER_BYTES + 1) : 1;
  localparam int CNT_W = $clog2(SYN_COUNT + 3);

  typedef struct packed {
    logic [7:0] byte_val;
    logic [1:0] mode;
    logic       transp;
  } scan_res_t;

  function automatic scan_res_t scan_step(input logic [7:0] b, input logic [1:0] mode,
                                          input logic transp, input logic en);
    scan_res_t r;
    logic      fix;
    fix      = 1'b0;
    r.mode   = mode;
    r.transp = transp;
    case (mode)
      SCAN_NORMAL: begin
        if (b == CH_DLE) begin
          r.mode = SCAN_DLE;
        end else begin
          fix = !transp;
        end
      end
      SCAN_DLE: begin
        if (b == CH_STX) begin
          r.transp = 1'b1;
          r.mode   = SCAN_NORMAL;
        end else if (b == CH_ETB || b == CH_ETX || b == CH_ITB) begin
          r.transp = 1'b0;
          r.mode   = SCAN_BCC1;
        end else begin
          fix    = !transp;
          r.mode = SCAN_NORMAL;
        end
      end
      SCAN_BCC1: r.mode = SCAN_BCC2;
      default:   r.mode = SCAN_NORMAL;
    endcase
    r.byte_val = (fix && en) ? {~^b[6:0], b[6:0]} : b;
    return r;
  endfunction

  logic [7:0]       sync_char_r;
  logic             parity_en_r;
  logic [HDR_W-1:0] hdr_left_r, hdr_left_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic [SYN_W-1:0] syn_left_r, syn_left_nxt;
  logic             body_r, body_nxt;
  logic             pad_r, pad_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic             transp_r, transp_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic             busy, out_free, step, last_step, accept, emit;
  logic [HDR_W-1:0] hdr_start;
  logic             body_take;
  logic [7:0]       cur_byte;
  logic             cur_last;
  scan_res_t        scan;

  assign busy     = (syn_left_r != '0) || body_r || pad_r;
  assign out_free = !out_valid_r || !out_stall;
  assign step     = busy && out_free;
  assign last_step = (syn_left_r == '0) ? (body_r ? !pad_r : pad_r)
                                        : (syn_left_r == SYN_W'(1) && !body_r && !pad_r);
  assign in_stall = busy && !(last_step && out_free);
  assign accept   = in_valid && !in_stall;

  assign hdr_start = in_data.frame_first ? HDR_W'(HEADER_BYTES) : hdr_left_r;
  assign body_take = (hdr_start == '0);

  always_comb begin
    if (syn_left_r != '0) begin
      cur_byte = sync_char_r;
      cur_last = 1'b0;
    end else if (body_r) begin
      cur_byte = byte_r;
      cur_last = 1'b0;
    end else begin
      cur_byte = CH_PAD;
      cur_last = 1'b1;
    end
  end

  assign scan = scan_step(cur_byte, mode_r, transp_r, parity_en_r);
  // results past the cap still move the scanner but are not sent
  assign emit = step && (int'(cnt_r) < RESULT_CAP);

  always_comb begin
    hdr_left_nxt  = hdr_left_r;
    byte_nxt      = byte_r;
    syn_left_nxt  = syn_left_r;
    body_nxt      = body_r;
    pad_nxt       = pad_r;
    cnt_nxt       = cnt_r;
    mode_nxt      = mode_r;
    transp_nxt    = transp_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (step) begin
      mode_nxt   = scan.mode;
      transp_nxt = scan.transp;
      cnt_nxt    = cnt_r + CNT_W'(1);
      if (syn_left_r != '0) begin
        syn_left_nxt = syn_left_r - SYN_W'(1);
      end else if (body_r) begin
        body_nxt = 1'b0;
      end else begin
        pad_nxt = 1'b0;
      end
    end

    if (accept) begin
      hdr_left_nxt = body_take ? hdr_start : hdr_start - HDR_W'(1);
      byte_nxt     = in_data.frame_byte;
      syn_left_nxt = in_data.frame_first ? SYN_W'(SYN_COUNT) : '0;
      body_nxt     = body_take;
      pad_nxt      = in_data.frame_last;
      cnt_nxt      = '0;
      if (in_data.frame_first) begin
        mode_nxt   = SCAN_NORMAL;
        transp_nxt = 1'b0;
      end
    end

    if (out_free) begin
      out_valid_nxt          = emit;
      out_data_nxt.line_byte = scan.byte_val;
      out_data_nxt.line_last = cur_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_char_r <= '0;
      parity_en_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_CHAR:  sync_char_r <= cfg_wdata;
        REG_PARITY_FIX: parity_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_left_r  <= '0;
      syn_left_r  <= '0;
      body_r      <= 1'b0;
      pad_r       <= 1'b0;
      cnt_r       <= '0;
      mode_r      <= SCAN_NORMAL;
      transp_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      hdr_left_r  <= hdr_left_nxt;
      syn_left_r  <= syn_left_nxt;
      body_r      <= body_nxt;
      pad_r       <= pad_nxt;
      cnt_r       <= cnt_nxt;
      mode_r      <= mode_nxt;
      transp_r    <= transp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* rtl/bsf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "bisync_tx_framer_parity_unit_defines.svh"

module bsf_checker (
  input wire                     clk,
  input wire                     rst_n,
  input wire                     out_valid,
  input wire                     out_stall,
  input wire bsf_pkg::out_item_t out_data
);

  import bsf_pkg::*;

  `BSF_ASSERT_NEXT(a_out_valid_hold, out_valid && out_stall, out_valid)
  `BSF_ASSERT_NEXT(a_out_data_hold, out_valid && out_stall, $stable(out_data))
  // output register comes out of reset empty
  `BSF_ASSERT_SAME(a_reset_empty, $past(!rst_n), !out_valid)
  // the pad is sent as is or with its parity forced
  `BSF_ASSERT_SAME(a_pad_value, out_valid && out_data.line_last, (out_data.line_byte == CH_PAD) || (out_data.line_byte == PAD_FIXED))

endmodule

bind bisync_tx_framer_parity_unit bsf_checker u_bsf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
